[rtl/core/sic_pkg.sv]
// ---------------------------------------------------------------------------
// sic_pkg: shared types and constants for the segment meeting classifier
// Holds the item structs, the stage-to-stage structs, the class codes and
// small arithmetic helpers used by the pipeline modules.
// ---------------------------------------------------------------------------
package sic_pkg;

  // Coordinate width actually used; wider settings act as the field width
  localparam int COORD_BITS = 16;
  localparam int FW         = 16;
  localparam int CW         = (COORD_BITS < FW) ? COORD_BITS : FW;

  // Arithmetic widths
  localparam int DFW = FW + 1;      // coordinate difference
  localparam int PRW = 2 * DFW;     // product of two differences
  localparam int XW  = PRW + 1;     // cross product
  localparam int LW  = PRW;         // squared length, unsigned
  localparam int MW  = XW - 1;      // cross product magnitude
  localparam int AW  = MW + DFW;    // magnitude of cross times difference
  localparam int NW  = AW + 2;      // rounded dividend 2n + d
  localparam int DVW = MW + 1;      // divisor 2d
  localparam int QW  = 18;          // quotient bits, |t * ab| stays below 2^17

  typedef enum logic [2:0] {
    CLS_NONE    = 3'd0,
    CLS_REGULAR = 3'd1,
    CLS_EDGE    = 3'd2,
    CLS_FIRST   = 3'd3,
    CLS_SECOND  = 3'd4
  } meet_class_t;

  typedef struct packed {
    logic signed [FW-1:0] ax;
    logic signed [FW-1:0] ay;
    logic signed [FW-1:0] bx;
    logic signed [FW-1:0] by_coord;
    logic signed [FW-1:0] px;
    logic signed [FW-1:0] py;
    logic signed [FW-1:0] qx;
    logic signed [FW-1:0] qy;
  } in_item_t;

  typedef struct packed {
    logic [2:0]           meet_class;
    logic signed [FW-1:0] cross_x;
    logic signed [FW-1:0] cross_y;
    logic                 point_valid;
  } out_item_t;

  // Cross products and lengths handed from the front end to the classifier
  typedef struct packed {
    logic signed [FW-1:0]  ax;
    logic signed [FW-1:0]  ay;
    logic signed [DFW-1:0] abx;
    logic signed [DFW-1:0] aby;
    logic signed [XW-1:0]  den;
    logic signed [XW-1:0]  c_edge;
    logic signed [XW-1:0]  c_abp;
    logic signed [XW-1:0]  c_abq;
    logic signed [XW-1:0]  c_pqa;
    logic signed [XW-1:0]  c_pqb;
    logic [LW-1:0]         l_ab;
    logic [LW-1:0]         l_pq;
    logic [LW-1:0]         l_ap;
    logic [LW-1:0]         l_aq;
    logic [LW-1:0]         l_bp;
    logic [LW-1:0]         l_bq;
    logic                  eq_ap;
    logic                  eq_aq;
    logic                  eq_bp;
    logic                  eq_bq;
  } geom_t;

  // Fields that ride along the divider
  typedef struct packed {
    meet_class_t          cls;
    logic signed [FW-1:0] ax;
    logic signed [FW-1:0] ay;
    logic                 neg_x;
    logic                 neg_y;
  } side_t;

  typedef struct packed {
    logic [NW-1:0]  num_x;
    logic [NW-1:0]  num_y;
    logic [DVW-1:0] den;
    side_t          side;
  } div_req_t;

  typedef struct packed {
    logic [QW-1:0] q_x;
    logic [QW-1:0] q_y;
    side_t         side;
  } div_res_t;

  // Keep the low CW bits of a field and sign-extend them
  function automatic logic signed [FW-1:0] sext_coord(input logic [FW-1:0] v);
    logic [FW-1:0] sh;
    sh = v << (FW - CW);
    return $signed(sh) >>> (FW - CW);
  endfunction

  function automatic logic signed [DFW-1:0] diff(input logic signed [FW-1:0] a,
                                                 input logic signed [FW-1:0] b);
    return DFW'(a) - DFW'(b);
  endfunction

  function automatic logic signed [XW-1:0] sub_pr(input logic signed [PRW-1:0] a,
                                                  input logic signed [PRW-1:0] b);
    return XW'(a) - XW'(b);
  endfunction

endpackage

[rtl/core/sic_front.sv]
// ---------------------------------------------------------------------------
// sic_front: differences, products and cross products
// Three register stages: coordinate differences, 17x17 products, then the
// cross products and squared lengths that the classifier compares.
// ---------------------------------------------------------------------------
module sic_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             valid_i,
  input  sic_pkg::in_item_t item_i,
  output logic             valid_o,
  output sic_pkg::geom_t   geom_o
);
  import sic_pkg::*;

  logic                  v1_r, v2_r, v3_r;
  logic signed [FW-1:0]  ax1_r, ay1_r, ax2_r, ay2_r;
  logic signed [DFW-1:0] abx1_r, aby1_r, pqx1_r, pqy1_r;
  logic signed [DFW-1:0] apx1_r, apy1_r, aqx1_r, aqy1_r;
  logic signed [DFW-1:0] bpx1_r, bpy1_r, bqx1_r, bqy1_r;
  logic signed [DFW-1:0] abx2_r, aby2_r;
  logic signed [PRW-1:0] den_a_r, den_b_r, edg_a_r, edg_b_r;
  logic signed [PRW-1:0] abp_a_r, abp_b_r, abq_a_r, abq_b_r;
  logic signed [PRW-1:0] pqa_a_r, pqa_b_r, pqb_a_r, pqb_b_r;
  logic signed [PRW-1:0] s_abx_r, s_aby_r, s_pqx_r, s_pqy_r;
  logic signed [PRW-1:0] s_apx_r, s_apy_r, s_aqx_r, s_aqy_r;
  logic signed [PRW-1:0] s_bpx_r, s_bpy_r, s_bqx_r, s_bqy_r;
  logic                  eq_ap2_r, eq_aq2_r, eq_bp2_r, eq_bq2_r;
  geom_t                 g_r;
  logic signed [FW-1:0]  sax, say, sbx, sby, spx, spy, sqx, sqy;

  // Sign-extend the coordinates
  always_comb begin
    sax = sext_coord(item_i.ax);
    say = sext_coord(item_i.ay);
    sbx = sext_coord(item_i.bx);
    sby = sext_coord(item_i.by_coord);
    spx = sext_coord(item_i.px);
    spy = sext_coord(item_i.py);
    sqx = sext_coord(item_i.qx);
    sqy = sext_coord(item_i.qy);
  end

  // Advance valid bits with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= valid_i;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // Stage 1: differences
  always_ff @(posedge clk) begin
    if (en) begin
      ax1_r  <= sax;
      ay1_r  <= say;
      abx1_r <= diff(sbx, sax);
      aby1_r <= diff(sby, say);
      pqx1_r <= diff(sqx, spx);
      pqy1_r <= diff(sqy, spy);
      apx1_r <= diff(spx, sax);
      apy1_r <= diff(spy, say);
      aqx1_r <= diff(sqx, sax);
      aqy1_r <= diff(sqy, say);
      bpx1_r <= diff(spx, sbx);
      bpy1_r <= diff(spy, sby);
      bqx1_r <= diff(sqx, sbx);
      bqy1_r <= diff(sqy, sby);
    end
  end

  // Stage 2: products and shared-endpoint flags
  always_ff @(posedge clk) begin
    if (en) begin
      ax2_r    <= ax1_r;
      ay2_r    <= ay1_r;
      abx2_r   <= abx1_r;
      aby2_r   <= aby1_r;
      den_a_r  <= abx1_r * pqy1_r;
      den_b_r  <= aby1_r * pqx1_r;
      edg_a_r  <= apx1_r * aqy1_r;
      edg_b_r  <= apy1_r * aqx1_r;
      abp_a_r  <= abx1_r * apy1_r;
      abp_b_r  <= aby1_r * apx1_r;
      abq_a_r  <= abx1_r * aqy1_r;
      abq_b_r  <= aby1_r * aqx1_r;
      pqa_a_r  <= pqx1_r * apy1_r;
      pqa_b_r  <= pqy1_r * apx1_r;
      pqb_a_r  <= pqx1_r * bpy1_r;
      pqb_b_r  <= pqy1_r * bpx1_r;
      s_abx_r  <= abx1_r * abx1_r;
      s_aby_r  <= aby1_r * aby1_r;
      s_pqx_r  <= pqx1_r * pqx1_r;
      s_pqy_r  <= pqy1_r * pqy1_r;
      s_apx_r  <= apx1_r * apx1_r;
      s_apy_r  <= apy1_r * apy1_r;
      s_aqx_r  <= aqx1_r * aqx1_r;
      s_aqy_r  <= aqy1_r * aqy1_r;
      s_bpx_r  <= bpx1_r * bpx1_r;
      s_bpy_r  <= bpy1_r * bpy1_r;
      s_bqx_r  <= bqx1_r * bqx1_r;
      s_bqy_r  <= bqy1_r * bqy1_r;
      eq_ap2_r <= (apx1_r == '0) && (apy1_r == '0);
      eq_aq2_r <= (aqx1_r == '0) && (aqy1_r == '0);
      eq_bp2_r <= (bpx1_r == '0) && (bpy1_r == '0);
      eq_bq2_r <= (bqx1_r == '0) && (bqy1_r == '0);
    end
  end

  // Stage 3: cross products and squared lengths
  always_ff @(posedge clk) begin
    if (en) begin
      g_r.ax     <= ax2_r;
      g_r.ay     <= ay2_r;
      g_r.abx    <= abx2_r;
      g_r.aby    <= aby2_r;
      g_r.den    <= sub_pr(den_a_r, den_b_r);
      g_r.c_edge <= sub_pr(edg_a_r, edg_b_r);
      g_r.c_abp  <= sub_pr(abp_a_r, abp_b_r);
      g_r.c_abq  <= sub_pr(abq_a_r, abq_b_r);
      g_r.c_pqa  <= sub_pr(pqa_a_r, pqa_b_r);
      g_r.c_pqb  <= sub_pr(pqb_a_r, pqb_b_r);
      g_r.l_ab   <= $unsigned(s_abx_r) + $unsigned(s_aby_r);
      g_r.l_pq   <= $unsigned(s_pqx_r) + $unsigned(s_pqy_r);
      g_r.l_ap   <= $unsigned(s_apx_r) + $unsigned(s_apy_r);
      g_r.l_aq   <= $unsigned(s_aqx_r) + $unsigned(s_aqy_r);
      g_r.l_bp   <= $unsigned(s_bpx_r) + $unsigned(s_bpy_r);
      g_r.l_bq   <= $unsigned(s_bqx_r) + $unsigned(s_bqy_r);
      g_r.eq_ap  <= eq_ap2_r;
      g_r.eq_aq  <= eq_aq2_r;
      g_r.eq_bp  <= eq_bp2_r;
      g_r.eq_bq  <= eq_bq2_r;
    end
  end

  assign valid_o = v3_r;
  assign geom_o  = g_r;

endmodule

[rtl/core/sic_classify.sv]
// ---------------------------------------------------------------------------
// sic_classify: endpoint location, class decision and dividend setup
// Stage 4 locates the endpoints and picks the class, stages 5 and 6 form
// the rounded dividend and divisor magnitudes for the crossing point.
// ---------------------------------------------------------------------------
module sic_classify (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              valid_i,
  input  sic_pkg::geom_t    geom_i,
  output logic              valid_o,
  output sic_pkg::div_req_t req_o
);
  import sic_pkg::*;

  typedef enum logic [2:0] {
    LOC_BOUND_A,
    LOC_BOUND_B,
    LOC_INSIDE,
    LOC_OUTSIDE,
    LOC_LEFT,
    LOC_RIGHT
  } loc_t;

  function automatic loc_t locate(input logic eq_u, input logic eq_v,
                                  input logic det_zero, input logic det_pos,
                                  input logic [LW-1:0] l_ux,
                                  input logic [LW-1:0] l_vx,
                                  input logic [LW-1:0] l_uv);
    loc_t r;
    if (eq_u) begin
      r = LOC_BOUND_A;
    end else if (eq_v) begin
      r = LOC_BOUND_B;
    end else if (det_zero) begin
      r = (l_ux < l_uv && l_vx < l_uv) ? LOC_INSIDE : LOC_OUTSIDE;
    end else begin
      r = det_pos ? LOC_LEFT : LOC_RIGHT;
    end
    return r;
  endfunction

  function automatic logic same_side(input loc_t l1, input loc_t l2);
    return (l1 == l2) && (l1 == LOC_LEFT || l1 == LOC_RIGHT);
  endfunction

  function automatic logic [MW-1:0] mag_x(input logic signed [XW-1:0] v);
    logic [XW-1:0] t;
    t = v[XW-1] ? (~v + 1'b1) : v;
    return t[MW-1:0];
  endfunction

  function automatic logic [DFW-1:0] mag_d(input logic signed [DFW-1:0] v);
    return v[DFW-1] ? (~v + 1'b1) : v;
  endfunction

  logic                  v4_r, v5_r, v6_r;
  side_t                 s4_r, s5_r;
  logic [MW-1:0]         mnum4_r, mden4_r, mden5_r;
  logic [DFW-1:0]        mabx4_r, maby4_r;
  logic [PRW-1:0]        phx5_r, plx5_r, phy5_r, ply5_r;
  div_req_t              req_r;
  loc_t                  lp, lq, la, lb;
  logic                  par;
  meet_class_t           cls;
  logic [AW-1:0]         an_x, an_y;

  // Locate the four endpoints and decide the class
  always_comb begin
    par = (geom_i.den == '0) || geom_i.eq_ap || geom_i.eq_aq ||
          geom_i.eq_bp || geom_i.eq_bq;
    lp  = locate(geom_i.eq_ap, geom_i.eq_bp, geom_i.c_abp == '0,
                 !geom_i.c_abp[XW-1] && geom_i.c_abp != '0,
                 geom_i.l_ap, geom_i.l_bp, geom_i.l_ab);
    lq  = locate(geom_i.eq_aq, geom_i.eq_bq, geom_i.c_abq == '0,
                 !geom_i.c_abq[XW-1] && geom_i.c_abq != '0,
                 geom_i.l_aq, geom_i.l_bq, geom_i.l_ab);
    // For the endpoints of AB against PQ the sign is flipped
    la  = locate(geom_i.eq_ap, geom_i.eq_aq, geom_i.c_pqa == '0,
                 geom_i.c_pqa[XW-1], geom_i.l_ap, geom_i.l_aq, geom_i.l_pq);
    lb  = locate(geom_i.eq_bp, geom_i.eq_bq, geom_i.c_pqb == '0,
                 geom_i.c_pqb[XW-1], geom_i.l_bp, geom_i.l_bq, geom_i.l_pq);
    if (par) begin
      cls = (geom_i.c_edge == '0 && geom_i.l_pq > geom_i.l_ab) ? CLS_EDGE : CLS_NONE;
    end else if (!same_side(lp, lq) && !same_side(la, lb) &&
                 lp != LOC_INSIDE && lq != LOC_INSIDE &&
                 la != LOC_INSIDE && lb != LOC_INSIDE) begin
      cls = CLS_REGULAR;
    end else if (la == LOC_INSIDE) begin
      cls = CLS_FIRST;
    end else if (lb == LOC_INSIDE) begin
      cls = CLS_SECOND;
    end else begin
      cls = CLS_NONE;
    end
  end

  // Recombine the partial products
  always_comb begin
    an_x = (AW'(phx5_r) << DFW) + AW'(plx5_r);
    an_y = (AW'(phy5_r) << DFW) + AW'(ply5_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (en) begin
      v4_r <= valid_i;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  // Stage 4: class, magnitudes and quotient signs
  // The dividend is minus the PQ cross term times AB, hence the inversion
  always_ff @(posedge clk) begin
    if (en) begin
      s4_r.cls   <= cls;
      s4_r.ax    <= geom_i.ax;
      s4_r.ay    <= geom_i.ay;
      s4_r.neg_x <= ~(geom_i.c_pqa[XW-1] ^ geom_i.abx[DFW-1] ^ geom_i.den[XW-1]);
      s4_r.neg_y <= ~(geom_i.c_pqa[XW-1] ^ geom_i.aby[DFW-1] ^ geom_i.den[XW-1]);
      mnum4_r    <= mag_x(geom_i.c_pqa);
      mden4_r    <= mag_x(geom_i.den);
      mabx4_r    <= mag_d(geom_i.abx);
      maby4_r    <= mag_d(geom_i.aby);
    end
  end

  // Stage 5: split the wide product into two 17x17 halves
  always_ff @(posedge clk) begin
    if (en) begin
      s5_r    <= s4_r;
      mden5_r <= mden4_r;
      phx5_r  <= mnum4_r[MW-1:DFW] * mabx4_r;
      plx5_r  <= mnum4_r[DFW-1:0] * mabx4_r;
      phy5_r  <= mnum4_r[MW-1:DFW] * maby4_r;
      ply5_r  <= mnum4_r[DFW-1:0] * maby4_r;
    end
  end

  // Stage 6: dividend 2n + d and divisor 2d for half-away rounding
  always_ff @(posedge clk) begin
    if (en) begin
      req_r.num_x <= (NW'(an_x) << 1) + NW'(mden5_r);
      req_r.num_y <= (NW'(an_y) << 1) + NW'(mden5_r);
      req_r.den   <= DVW'(mden5_r) << 1;
      req_r.side  <= s5_r;
    end
  end

  assign valid_o = v6_r;
  assign req_o   = req_r;

endmodule

[rtl/core/sic_divider.sv]
// ---------------------------------------------------------------------------
// sic_divider: pipelined restoring divider for both coordinates
// One quotient bit per stage, most significant first, for x and y side by
// side; the divisor and the side fields travel with each stage.
// ---------------------------------------------------------------------------
module sic_divider (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              valid_i,
  input  sic_pkg::div_req_t req_i,
  output logic              valid_o,
  output sic_pkg::div_res_t res_o
);
  import sic_pkg::*;

  logic [QW-1:0]  v_r;
  logic [NW-1:0]  rx_r [QW];
  logic [NW-1:0]  ry_r [QW];
  logic [DVW-1:0] d_r  [QW];
  logic [QW-1:0]  qx_r [QW];
  logic [QW-1:0]  qy_r [QW];
  side_t          s_r  [QW];

  logic [NW-1:0]  rin_x [QW];
  logic [NW-1:0]  rin_y [QW];
  logic [DVW-1:0] din   [QW];
  logic [QW-1:0]  qin_x [QW];
  logic [QW-1:0]  qin_y [QW];
  side_t          sin   [QW];
  logic [NW-1:0]  dsh   [QW];
  logic           ge_x  [QW];
  logic           ge_y  [QW];
  logic [NW-1:0]  rx_nxt [QW];
  logic [NW-1:0]  ry_nxt [QW];
  logic [QW-1:0]  qx_nxt [QW];
  logic [QW-1:0]  qy_nxt [QW];

  // Stage inputs: the request for the first stage, the previous stage after
  always_comb begin
    rin_x[0] = req_i.num_x;
    rin_y[0] = req_i.num_y;
    din[0]   = req_i.den;
    qin_x[0] = '0;
    qin_y[0] = '0;
    sin[0]   = req_i.side;
    for (int k = 1; k < QW; k++) begin
      rin_x[k] = rx_r[k-1];
      rin_y[k] = ry_r[k-1];
      din[k]   = d_r[k-1];
      qin_x[k] = qx_r[k-1];
      qin_y[k] = qy_r[k-1];
      sin[k]   = s_r[k-1];
    end
  end

  // Compare and subtract the shifted divisor in each stage
  always_comb begin
    for (int k = 0; k < QW; k++) begin
      dsh[k]    = NW'(din[k]) << (QW - 1 - k);
      ge_x[k]   = rin_x[k] >= dsh[k];
      ge_y[k]   = rin_y[k] >= dsh[k];
      rx_nxt[k] = ge_x[k] ? rin_x[k] - dsh[k] : rin_x[k];
      ry_nxt[k] = ge_y[k] ? rin_y[k] - dsh[k] : rin_y[k];
      qx_nxt[k] = qin_x[k] | (QW'(ge_x[k]) << (QW - 1 - k));
      qy_nxt[k] = qin_y[k] | (QW'(ge_y[k]) << (QW - 1 - k));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[QW-2:0], valid_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < QW; k++) begin
        rx_r[k] <= rx_nxt[k];
        ry_r[k] <= ry_nxt[k];
        d_r[k]  <= din[k];
        qx_r[k] <= qx_nxt[k];
        qy_r[k] <= qy_nxt[k];
        s_r[k]  <= sin[k];
      end
    end
  end

  assign valid_o    = v_r[QW-1];
  assign res_o.q_x  = qx_r[QW-1];
  assign res_o.q_y  = qy_r[QW-1];
  assign res_o.side = s_r[QW-1];

endmodule

[rtl/core/segment_intersection_classify_point.sv]
// ---------------------------------------------------------------------------
// segment_intersection_classify_point: segment meeting classifier
// Classifies how segments AB and PQ meet and gives the crossing point for
// the regular class.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel in_valid / in_stall / in_data carries one segment pair per
//   item; output channel out_valid / out_stall / out_data carries one result
//   item per input item, in order.
//   From acceptance to out_valid an item passes 3 front-end stages
//   (differences, products, cross products), 3 classify stages, 18 divider
//   stages (one quotient bit each) and the output register.
//   Throughput is one item per cycle while the pipeline advances; every
//   stage registers its own valid bit, so new items enter as older ones move on.
//   The pipeline advances as a whole whenever the output register is empty
//   or being taken. While the receiver stalls a held result, in_stall is
//   high and every stage holds; nothing is lost or repeated.
//   Reset (rst_n low, synchronous) clears all valid bits; the block takes
//   items from the first cycle after reset.
// ---------------------------------------------------------------------------
module segment_intersection_classify_point (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  sic_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output sic_pkg::out_item_t out_data
);
  import sic_pkg::*;

  logic      en;
  logic      fr_valid, cl_valid, dv_valid;
  geom_t     geom;
  div_req_t  req;
  div_res_t  res;
  logic      out_valid_r;
  out_item_t out_r;
  logic [QW-1:0] qs_x, qs_y;
  logic          regular;

  // Advance everything unless a held result is stalled
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  sic_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (in_valid),
    .item_i  (in_data),
    .valid_o (fr_valid),
    .geom_o  (geom)
  );

  sic_classify u_classify (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (fr_valid),
    .geom_i  (geom),
    .valid_o (cl_valid),
    .req_o   (req)
  );

  sic_divider u_divider (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (cl_valid),
    .req_i   (req),
    .valid_o (dv_valid),
    .res_o   (res)
  );

  // Apply quotient signs and offset by A
  always_comb begin
    qs_x    = res.side.neg_x ? (~res.q_x + 1'b1) : res.q_x;
    qs_y    = res.side.neg_y ? (~res.q_y + 1'b1) : res.q_y;
    regular = (res.side.cls == CLS_REGULAR);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_valid;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (en) begin
      out_r.meet_class  <= res.side.cls;
      out_r.cross_x     <= regular ? res.side.ax + $signed(qs_x[FW-1:0]) : '1;
      out_r.cross_y     <= regular ? res.side.ay + $signed(qs_y[FW-1:0]) : '1;
      out_r.point_valid <= regular;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[rtl/core/sic_checker.sv]
// ---------------------------------------------------------------------------
// sic_checker: port-level checks for the segment meeting classifier
// Watches the handshakes and result fields at the top-level ports.
// ---------------------------------------------------------------------------
module sic_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input sic_pkg::out_item_t out_data
);
  import sic_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Stall the input only behind a stalled result
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

  // Drop all results at reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Point only for the regular class, otherwise both coordinates are -1
  a_point: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.point_valid == (out_data.meet_class == CLS_REGULAR)) &&
                  (out_data.point_valid ||
                   (out_data.cross_x == '1 && out_data.cross_y == '1)))
    else $error("point fields disagree with class");

  a_unused_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |-> !(out_valid && out_stall))
    else $error("item accepted while result stalled");

endmodule

bind segment_intersection_classify_point sic_checker u_sic_checker (.*);
